// ----- hdl/ncmw_pkg.sv -----
// ----------------------------------------------------------------------------
// ncmw_pkg: shared types and constants for the nearest-center mesh walk.
// Table sizes, field widths, opcodes and the front-to-back request format.
// ----------------------------------------------------------------------------
`default_nettype none

package ncmw_pkg;

    localparam int MaxElements  = 4096;
    localparam int MaxNeighbors = 8;
    localparam int ElemW        = $clog2(MaxElements);
    localparam int SlotW        = $clog2(MaxNeighbors);
    localparam int CountW       = $clog2(MaxNeighbors + 1);
    localparam int IdW          = 13;
    localparam int CoordW       = 31;
    localparam int DistW        = 66;
    localparam int ValueW       = 16;
    localparam int CfgW         = 13;
    localparam int FifoDepth    = 4;
    localparam int FifoAw       = $clog2(FifoDepth);

    localparam logic [IdW-1:0] IdSat = {IdW{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD_CENTER   = 2'd0,
        OP_LOAD_NEIGHBOR = 2'd1,
        OP_LOAD_OWNER    = 2'd2,
        OP_TRACK         = 2'd3
    } opcode_t;

    localparam logic CFG_ELEMENT_COUNT = 1'b0;
    localparam logic CFG_OWNER_MAP     = 1'b1;

    typedef struct packed {
        opcode_t                   op;
        logic [ElemW-1:0]          elem;
        logic [SlotW-1:0]          slot;
        logic                      is_count;
        logic [ValueW-1:0]         value;
        logic signed [CoordW-1:0]  x;
        logic signed [CoordW-1:0]  y;
        logic signed [CoordW-1:0]  z;
    } req_t;

    typedef struct packed {
        logic [ElemW-1:0]  final_element;
        logic [ValueW-1:0] owner_process;
        logic              owner_valid;
    } res_t;

endpackage

`default_nettype wire

// ----- hdl/ncmw_front.sv -----
// ----------------------------------------------------------------------------
// ncmw_front: input classifier.
// Drops items that cause nothing, clamps load values and queues requests.
// ----------------------------------------------------------------------------
`default_nettype none

module ncmw_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         opcode,
    input  wire logic [11:0]        element_index,
    input  wire logic [3:0]         slot_index,
    input  wire logic [15:0]        table_value,
    input  wire logic signed [30:0] coord_x,
    input  wire logic signed [30:0] coord_y,
    input  wire logic signed [30:0] coord_z,
    input  wire logic               point_active,
    output ncmw_pkg::req_t          req,
    output logic                    req_valid,
    input  wire logic               req_take
);
    import ncmw_pkg::*;

    req_t               fifo_mem [FifoDepth];
    logic [FifoAw-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FifoAw:0]    cnt_reg;
    logic               keep;
    logic               acc;
    req_t               item;

    always_comb
    begin
        item          = '0;
        item.op       = opcode_t'(opcode);
        item.elem     = element_index[ElemW-1:0];
        item.x        = coord_x;
        item.y        = coord_y;
        item.z        = coord_z;
        item.value    = table_value;
        item.is_count = (slot_index == 4'd0);
        item.slot     = SlotW'(slot_index - 4'd1);
        keep          = 1'b1;
        case (item.op)
            OP_LOAD_NEIGHBOR:
            begin
                if (item.is_count)
                begin
                    if (table_value > 16'(MaxNeighbors))
                        item.value = 16'(MaxNeighbors);
                end
                else if (slot_index > 4'(MaxNeighbors))
                    keep = 1'b0;
                else if (table_value > 16'(IdSat))
                    item.value = 16'(IdSat);
            end
            OP_TRACK: keep = point_active;
            default: keep = 1'b1;
        endcase
    end

    assign full      = (cnt_reg == (FifoAw+1)'(FifoDepth));
    assign acc       = push && !full;
    assign req_valid = (cnt_reg != '0);
    assign req       = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (acc && keep)
            fifo_mem[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (acc && keep)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (req_take)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (FifoAw+1)'(acc && keep) - (FifoAw+1)'(req_take);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) req_take |-> req_valid)
        else $error("take from empty request queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (FifoAw+1)'(FifoDepth))
        else $error("request queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && keep && !req_take) |=> req_valid)
        else $error("kept item lost");

endmodule

`default_nettype wire

// ----- hdl/ncmw_back.sv -----
// ----------------------------------------------------------------------------
// ncmw_back: table storage and walk sequencer.
// Writes load requests into the tables and walks tracks over the mesh.
// ----------------------------------------------------------------------------
`default_nettype none

module ncmw_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ncmw_pkg::req_t  req,
    input  wire logic            req_valid,
    output logic                 req_take,
    input  wire logic [12:0]     cnt_cfg,
    input  wire logic            owner_en,
    output ncmw_pkg::res_t       res,
    output logic                 res_valid,
    input  wire logic            res_take
);
    import ncmw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CUR_RD, S_CUR_WAIT, S_NB_RD, S_NB_WAIT, S_CTR_WAIT,
        S_SQ, S_SUM, S_CMP, S_OWN_WAIT, S_OUT
    } state_t;

    logic signed [CoordW-1:0] cx_mem [MaxElements];
    logic signed [CoordW-1:0] cy_mem [MaxElements];
    logic signed [CoordW-1:0] cz_mem [MaxElements];
    logic [CountW-1:0]        ncnt_mem [MaxElements];
    logic [IdW-1:0]           nid_mem [MaxElements*MaxNeighbors];
    logic [ValueW-1:0]        own_mem [MaxElements];

    state_t                   state_reg;
    req_t                     job_reg;
    logic [ElemW-1:0]         cur_reg, next_reg, cand_reg, own_addr;
    logic [ElemW-1:0]         ctr_addr;
    logic                     moved_reg, is_self_reg;
    logic [CountW-1:0]        n_reg;
    logic [CountW:0]          i_reg;
    logic [DistW-1:0]         best_reg, dist_reg;
    logic [63:0]              sqx_reg, sqy_reg, sqz_reg;
    logic signed [CoordW:0]   dx_reg, dy_reg, dz_reg;
    logic signed [CoordW-1:0] rx_reg, ry_reg, rz_reg;
    logic [CountW-1:0]        rn_reg;
    logic [IdW-1:0]           rid_reg;
    logic [ValueW-1:0]        rown_reg;
    logic [ElemW+SlotW-1:0]   nid_rd_addr;
    logic [ElemW-1:0]         nb_elem;
    logic                     nb_ok;
    res_t                     res_reg;
    logic                     res_valid_reg;
    logic                     res_load;
    logic [CoordW-1:0]        ax, ay, az;

    // Table writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            case (req.op)
                OP_LOAD_CENTER:
                begin
                    cx_mem[req.elem] <= req.x;
                    cy_mem[req.elem] <= req.y;
                    cz_mem[req.elem] <= req.z;
                end
                OP_LOAD_NEIGHBOR:
                begin
                    if (req.is_count)
                        ncnt_mem[req.elem] <= req.value[CountW-1:0];
                    else
                        nid_mem[{req.elem, req.slot}] <= req.value[IdW-1:0];
                end
                OP_LOAD_OWNER: own_mem[req.elem] <= req.value;
                default: ;
            endcase
        end
        rx_reg   <= cx_mem[ctr_addr];
        ry_reg   <= cy_mem[ctr_addr];
        rz_reg   <= cz_mem[ctr_addr];
        rn_reg   <= ncnt_mem[cur_reg];
        rid_reg  <= nid_mem[nid_rd_addr];
        rown_reg <= own_mem[own_addr];
    end

    assign nid_rd_addr = {cur_reg, i_reg[SlotW-1:0]};
    assign ctr_addr    = (state_reg == S_NB_WAIT) ? nb_elem : cur_reg;
    assign own_addr    = cur_reg;
    assign nb_elem     = ElemW'(rid_reg - 1'b1);
    assign nb_ok       = (rid_reg != '0) && ({1'b0, rid_reg - 1'b1} < {1'b0, cnt_cfg})
                         && ((rid_reg - 1'b1) < IdW'(MaxElements));

    function automatic logic [CoordW-1:0] absd(input logic signed [CoordW:0] d);
        absd = d[CoordW] ? CoordW'(-d) : d[CoordW-1:0];
    endfunction

    assign ax = absd(dx_reg);
    assign ay = absd(dy_reg);
    assign az = absd(dz_reg);

    assign req_take  = (state_reg == S_IDLE) && req_valid;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;
    assign res_load  = (state_reg == S_OUT) && (!res_valid_reg || res_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_take)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req.op == OP_TRACK)
                    begin
                        job_reg   <= req;
                        cur_reg   <= req.elem;
                        state_reg <= S_CUR_RD;
                    end
                end
                S_CUR_RD: state_reg <= S_CUR_WAIT;
                S_CUR_WAIT:
                begin
                    // Center of the current element and its count are here.
                    n_reg       <= (rn_reg > CountW'(MaxNeighbors)) ?
                                   CountW'(MaxNeighbors) : rn_reg;
                    is_self_reg <= 1'b1;
                    moved_reg   <= 1'b0;
                    next_reg    <= cur_reg;
                    i_reg       <= '0;
                    dx_reg      <= (CoordW+1)'(job_reg.x) - (CoordW+1)'(rx_reg);
                    dy_reg      <= (CoordW+1)'(job_reg.y) - (CoordW+1)'(ry_reg);
                    dz_reg      <= (CoordW+1)'(job_reg.z) - (CoordW+1)'(rz_reg);
                    state_reg   <= S_SQ;
                end
                S_NB_RD:
                begin
                    if (i_reg >= (CountW+1)'(n_reg))
                    begin
                        if (moved_reg)
                        begin
                            cur_reg   <= next_reg;
                            state_reg <= S_CUR_RD;
                        end
                        else
                            state_reg <= S_OWN_WAIT;
                    end
                    else
                        state_reg <= S_NB_WAIT;
                end
                S_NB_WAIT:
                begin
                    if (nb_ok)
                    begin
                        cand_reg  <= nb_elem;
                        state_reg <= S_CTR_WAIT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_NB_RD;
                    end
                end
                S_CTR_WAIT:
                begin
                    is_self_reg <= 1'b0;
                    dx_reg      <= (CoordW+1)'(job_reg.x) - (CoordW+1)'(rx_reg);
                    dy_reg      <= (CoordW+1)'(job_reg.y) - (CoordW+1)'(ry_reg);
                    dz_reg      <= (CoordW+1)'(job_reg.z) - (CoordW+1)'(rz_reg);
                    state_reg   <= S_SQ;
                end
                S_SQ:
                begin
                    sqx_reg   <= 64'(ax) * 64'(ax);
                    sqy_reg   <= 64'(ay) * 64'(ay);
                    sqz_reg   <= 64'(az) * 64'(az);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    dist_reg  <= DistW'(sqx_reg) + DistW'(sqy_reg) + DistW'(sqz_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (is_self_reg)
                        best_reg <= dist_reg;
                    else
                    begin
                        if (dist_reg < best_reg)
                        begin
                            best_reg  <= dist_reg;
                            next_reg  <= cand_reg;
                            moved_reg <= 1'b1;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                    state_reg <= S_NB_RD;
                end
                S_OWN_WAIT: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (res_load)
                    begin
                        res_reg.final_element <= cur_reg;
                        res_reg.owner_process <= owner_en ? rown_reg : '0;
                        res_reg.owner_valid   <= owner_en;
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> state_reg == S_IDLE)
        else $error("request taken while walking");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && !is_self_reg && dist_reg < best_reg) |=> moved_reg)
        else $error("closer neighbor not recorded");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_take) |=> $stable(res_reg))
        else $error("waiting result changed");

endmodule

`default_nettype wire

// ----- hdl/nearest_center_mesh_walk.sv -----
// ----------------------------------------------------------------------------
// nearest_center_mesh_walk: greedy point location over a mesh table.
// Loads centers, neighbor lists and owners; walks tracks to the closest center.
// ----------------------------------------------------------------------------
//  channel   | handshake           | contents
//  input     | push / full         | opcode, element_index, slot_index, ...
//  result    | pop / empty         | final_element, owner_process, owner_valid
//  config    | cfg_we              | cfg_index, cfg_data
//
// A load request is written into its table when the back end takes it. A
// track reads each visited element and its neighbor slots one by one through
// the single read port of the center tables; the element and each in-range
// neighbor pass the multiply-add-compare sequence, but skipped slots do not.
// Reset clears control state only; tables hold nothing until loaded.
// The front queue keeps taking requests while a walk runs, and a finished
// result waits in the output register until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_center_mesh_walk (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         opcode,
    input  wire logic [11:0]        element_index,
    input  wire logic [3:0]         slot_index,
    input  wire logic [15:0]        table_value,
    input  wire logic signed [30:0] coord_x,
    input  wire logic signed [30:0] coord_y,
    input  wire logic signed [30:0] coord_z,
    input  wire logic               point_active,
    output logic                    empty,
    input  wire logic               pop,
    output logic [11:0]             final_element,
    output logic [15:0]             owner_process,
    output logic                    owner_valid,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [12:0]        cfg_data
);
    import ncmw_pkg::*;

    req_t        req;
    res_t        res;
    logic        req_valid, req_take, res_valid;
    logic [12:0] count_reg;
    logic        owner_en_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 13'd4096;
            owner_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ELEMENT_COUNT)
                count_reg <= cfg_data;
            else
                owner_en_reg <= cfg_data[0];
        end
    end

    ncmw_front u_front (
        .clk, .rst_n, .push, .full, .opcode, .element_index, .slot_index,
        .table_value, .coord_x, .coord_y, .coord_z, .point_active,
        .req, .req_valid, .req_take
    );

    ncmw_back u_back (
        .clk, .rst_n, .req, .req_valid, .req_take,
        .cnt_cfg(count_reg), .owner_en(owner_en_reg),
        .res, .res_valid, .res_take(pop && res_valid)
    );

    assign empty         = !res_valid;
    assign final_element = res.final_element;
    assign owner_process = res.owner_process;
    assign owner_valid   = res.owner_valid;

    assert property (@(posedge clk) disable iff (!rst_n)
        owner_valid && !empty |-> 1'b1 == owner_en_reg || $past(cfg_we))
        else $error("owner flag differs from map enable");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !owner_valid) |-> owner_process == '0)
        else $error("owner set while map disabled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for nearest_center_mesh_walk.
// Loads a small mesh, then sends directed and random requests through the
// push/full queue while a scoreboard predicts every walk result. Results
// popped from the output queue are compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ncmw_pkg::*;

    // Elements 0 .. MeshSize-1 are always fully loaded: center, owner, count
    // and all eight neighbor slots. Neighbor ids never point at elements
    // MeshSize .. MaxElements-1, so no walk ever reads an unloaded entry.
    localparam int MeshSize     = 16;
    localparam int DrainCycles  = 1500;
    localparam int WatchdogMax  = 8000;
    localparam int RandPerPhase = 200;

    typedef struct {
        logic [11:0] final_element;
        logic [15:0] owner_process;
        logic        owner_valid;
    } walk_result_t;

    // The scoreboard keeps its own copy of the mesh table and registers.
    // Every accepted request updates the copy; an active track predicts the
    // element where the greedy walk stops.
    class walk_scoreboard;
        logic signed [30:0] cx [MaxElements];
        logic signed [30:0] cy [MaxElements];
        logic signed [30:0] cz [MaxElements];
        int                 nbr_count [MaxElements];
        int                 nbr_id [MaxElements][MaxNeighbors];
        logic [15:0]        owner [MaxElements];
        int                 elem_limit;
        bit                 owner_map;
        walk_result_t       expected_results[$];
        int                 mismatches;
        int                 results_checked;

        function new();
            elem_limit = 4096;
            owner_map = 0;
            mismatches = 0;
            results_checked = 0;
            for (int i = 0; i < MaxElements; i++)
            begin
                cx[i] = 0; cy[i] = 0; cz[i] = 0; nbr_count[i] = 0; owner[i] = 0;
                for (int j = 0; j < MaxNeighbors; j++)
                    nbr_id[i][j] = 0;
            end
        endfunction

        function automatic logic [65:0] axis_sq(logic signed [30:0] t,
                                                 logic signed [30:0] c);
            logic signed [32:0] d;
            logic [65:0] m;
            d = 33'(t) - 33'(c);
            if (d < 0)
                d = -d;
            m = {33'b0, d};
            return m * m;
        endfunction

        function automatic logic [65:0] center_dist(int e, logic signed [30:0] tx,
                                                     logic signed [30:0] ty,
                                                     logic signed [30:0] tz);
            return axis_sq(tx, cx[e]) + axis_sq(ty, cy[e]) + axis_sq(tz, cz[e]);
        endfunction

        // Greedy descent: each step moves to the nearest, strictly closer neighbor.
        function automatic int predict_walk(int start, logic signed [30:0] tx,
                                            logic signed [30:0] ty,
                                            logic signed [30:0] tz);
            int cur;
            int next;
            int nb;
            bit moved;
            logic [65:0] best;
            logic [65:0] d;
            cur = start;
            forever
            begin
                best = center_dist(cur, tx, ty, tz);
                moved = 0;
                next = cur;
                for (int i = 0; i < nbr_count[cur]; i++)
                begin
                    if (nbr_id[cur][i] == 0)
                        continue;
                    nb = nbr_id[cur][i] - 1;
                    if (nb >= elem_limit || nb >= MaxElements)
                        continue;
                    d = center_dist(nb, tx, ty, tz);
                    if (d < best)
                    begin
                        best = d;
                        next = nb;
                        moved = 1;
                    end
                end
                if (!moved)
                    break;
                cur = next;
            end
            return cur;
        endfunction

        function void note_request(opcode_t op, int elem, int slot, int value,
                                   logic signed [30:0] x, logic signed [30:0] y,
                                   logic signed [30:0] z, bit active);
            walk_result_t r;
            case (op)
                OP_LOAD_CENTER:
                begin
                    cx[elem] = x; cy[elem] = y; cz[elem] = z;
                end
                OP_LOAD_NEIGHBOR:
                begin
                    if (slot == 0)
                        nbr_count[elem] = (value > MaxNeighbors) ? MaxNeighbors : value;
                    else if (slot <= MaxNeighbors)
                        nbr_id[elem][slot-1] = (value > 8191) ? 8191 : value;
                end
                OP_LOAD_OWNER:
                    owner[elem] = value[15:0];
                default:
                begin
                    if (active)
                    begin
                        r.final_element = 12'(predict_walk(elem, x, y, z));
                        r.owner_process = owner_map ? owner[r.final_element] : 16'd0;
                        r.owner_valid = owner_map;
                        expected_results.push_back(r);
                    end
                end
            endcase
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [11:0] fe, logic [15:0] op, logic ov);
            walk_result_t e;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with nothing expected, element %0d", fe));
                return;
            end
            e = expected_results.pop_front();
            results_checked++;
            if (fe !== e.final_element)
                report($sformatf("final_element %0d, expected %0d", fe, e.final_element));
            if (op !== e.owner_process)
                report($sformatf("owner_process %0d, expected %0d", op, e.owner_process));
            if (ov !== e.owner_valid)
                report($sformatf("owner_valid %0b, expected %0b", ov, e.owner_valid));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [1:0]         opcode;
    logic [11:0]        element_index;
    logic [3:0]         slot_index;
    logic [15:0]        table_value;
    logic signed [30:0] coord_x;
    logic signed [30:0] coord_y;
    logic signed [30:0] coord_z;
    logic               point_active;
    logic               empty;
    logic               pop;
    logic [11:0]        final_element;
    logic [15:0]        owner_process;
    logic               owner_valid;
    logic               cfg_we;
    logic               cfg_index;
    logic [12:0]        cfg_data;

    nearest_center_mesh_walk uut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .opcode(opcode), .element_index(element_index), .slot_index(slot_index),
        .table_value(table_value), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .point_active(point_active),
        .empty(empty), .pop(pop),
        .final_element(final_element), .owner_process(owner_process),
        .owner_valid(owner_valid),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    walk_scoreboard mesh_sb;
    int  requests_sent;
    int  tracks_sent;
    int  stall_cycles;
    int  hold_off_cycles;
    bit  sender_gaps;
    bit  receiver_gaps;

    // Free-running 2 ns clock.
    initial clk = 0;
    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Watchdog: any stretch without a single accepted request or result that
    // is far longer than the slowest walk plus a hold-off ends the run.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WatchdogMax)
        begin
            $display("Timeout: no request or result accepted for %0d cycles",
                     stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side. Each result waits a random number of cycles before pop is
    // raised, except when gaps are switched off. A pending hold-off keeps pop
    // low for a long stretch so that the block backs up into its input queue.
    initial
    begin
        int gap;
        pop = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                pop = 0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            gap = receiver_gaps ? $urandom_range(0, 9) : 0;
            if (gap > 0)
            begin
                pop = 0;
                repeat (gap) @(negedge clk);
            end
            pop = 1;
            do @(posedge clk); while (empty);
            mesh_sb.check_result(final_element, owner_process, owner_valid);
        end
    end

    // Sends one request. Inputs change only at the falling edge; the request
    // counts as accepted at the first rising edge with full low.
    task automatic send_request(opcode_t op, int elem, int slot, int value,
                                logic signed [30:0] x, logic signed [30:0] y,
                                logic signed [30:0] z, bit active);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            push = 0;
            repeat (gap) @(negedge clk);
        end
        push = 1;
        opcode = op;
        element_index = 12'(elem);
        slot_index = 4'(slot);
        table_value = 16'(value);
        coord_x = x;
        coord_y = y;
        coord_z = z;
        point_active = active;
        do @(posedge clk); while (full);
        mesh_sb.note_request(op, elem, slot, value, x, y, z, active);
        requests_sent++;
        if (op == OP_TRACK && active)
            tracks_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        push = 0;
        while (mesh_sb.expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Registers change only with the block idle: all results in, and enough
    // further cycles for any load request still queued to be taken.
    task automatic write_config(logic idx, int value);
        drain_results();
        repeat (DrainCycles) @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = 13'(value);
        @(negedge clk);
        cfg_we = 0;
        if (idx == CFG_ELEMENT_COUNT)
            mesh_sb.elem_limit = value;
        else
            mesh_sb.owner_map = value[0];
    endtask

    function automatic logic signed [30:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 31'sh3FFFFFFF;
            1: return -31'sh40000000;
            2, 3: return 31'($urandom());
            default: return 31'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // Neighbor ids: empty, inside the loaded mesh, or beyond every element.
    function automatic int pick_neighbor_id();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(4097, 65535);
            default: return $urandom_range(1, MeshSize);
        endcase
    endfunction

    // Centers on a 4-wide grid, neighbors at index +-1 and +-4 mod MeshSize,
    // plus an empty, a saturating, an out-of-range and a random id.
    task automatic load_mesh();
        int nb [MaxNeighbors];
        for (int i = 0; i < MeshSize; i++)
        begin
            send_request(OP_LOAD_CENTER, i, 0, 0, 31'((i % 4) * 1000),
                         31'((i / 4) * 1000), 31'(0), 0);
            send_request(OP_LOAD_OWNER, i, 0, 100 + i, 0, 0, 0, 0);
            send_request(OP_LOAD_NEIGHBOR, i, 0, MaxNeighbors, 0, 0, 0, 0);
            nb[0] = (i + 1) % MeshSize + 1;
            nb[1] = (i + MeshSize - 1) % MeshSize + 1;
            nb[2] = (i + 4) % MeshSize + 1;
            nb[3] = (i + MeshSize - 4) % MeshSize + 1;
            nb[4] = 0;
            nb[5] = 65535;
            nb[6] = 4097;
            nb[7] = pick_neighbor_id();
            for (int s = 1; s <= MaxNeighbors; s++)
                send_request(OP_LOAD_NEIGHBOR, i, s, nb[s-1], 0, 0, 0, 0);
        end
    endtask

    // Directed corner cases: coordinate extremes, a saturating count, a
    // saturating id, a bad slot, an inactive point on a far element, a start
    // beyond the element count and the top element index on every opcode.
    task automatic directed_requests();
        send_request(OP_TRACK, 0, 0, 0, 31'sh3FFFFFFF, 31'sh3FFFFFFF, 31'sh3FFFFFFF, 1);
        send_request(OP_TRACK, 15, 0, 0, -31'sh40000000, -31'sh40000000,
                     -31'sh40000000, 1);
        send_request(OP_LOAD_CENTER, 3, 0, 0, 31'sh3FFFFFFF, -31'sh40000000,
                     31'sh3FFFFFFF, 0);
        send_request(OP_TRACK, 5, 0, 0, 31'sh3FFFFFFF, -31'sh40000000,
                     31'sh3FFFFFFF, 1);
        send_request(OP_TRACK, 3, 0, 0, -31'sh40000000, 31'sh3FFFFFFF,
                     -31'sh40000000, 1);
        send_request(OP_LOAD_NEIGHBOR, 2, 0, 65535, 0, 0, 0, 0);
        send_request(OP_LOAD_NEIGHBOR, 2, 1, 65535, 0, 0, 0, 0);
        send_request(OP_LOAD_NEIGHBOR, 2, 15, 1, 0, 0, 0, 0);
        send_request(OP_LOAD_NEIGHBOR, 2, 9, 1, 0, 0, 0, 0);
        send_request(OP_TRACK, 2, 0, 0, 0, 0, 0, 1);
        send_request(OP_LOAD_NEIGHBOR, 7, 0, 0, 0, 0, 0, 0);
        send_request(OP_TRACK, 7, 0, 0, 0, 0, 0, 1);
        send_request(OP_LOAD_NEIGHBOR, 7, 0, 3, 0, 0, 0, 0);
        send_request(OP_TRACK, 4095, 15, 65535, 31'sh3FFFFFFF, -31'sh40000000, 0, 0);
        send_request(OP_LOAD_CENTER, 4095, 0, 0, -31'sh40000000, 31'sh3FFFFFFF, 0, 0);
        send_request(OP_LOAD_NEIGHBOR, 4095, 8, 65535, 0, 0, 0, 0);
        send_request(OP_LOAD_OWNER, 4095, 0, 65535, 0, 0, 0, 0);
        send_request(OP_LOAD_OWNER, 9, 0, 65535, 0, 0, 0, 0);
        send_request(OP_TRACK, 9, 0, 0, 31'(3000), 31'(3000), 0, 1);
        send_request(OP_TRACK, 12, 0, 0, 31'(1000), 31'(0), 0, 1);
    endtask

    // Mostly tracks over the loaded mesh with random targets; the rest keeps
    // reshaping the mesh and adds noise such as bad slots and far elements.
    task automatic random_requests(int n);
        int e;
        int slot;
        for (int k = 0; k < n; k++)
        begin
            if (k == n / 2)
                sender_gaps = 0;
            e = $urandom_range(0, MeshSize - 1);
            case ($urandom_range(0, 19))
                0, 1, 2:
                    send_request(OP_LOAD_CENTER, e, 0, 0, pick_coord(), pick_coord(),
                                 pick_coord(), 0);
                3, 4, 5:
                begin
                    slot = $urandom_range(0, 15);
                    send_request(OP_LOAD_NEIGHBOR, e, slot,
                                 (slot == 0) ? $urandom_range(0, 15) : pick_neighbor_id(),
                                 0, 0, 0, 0);
                end
                6:
                    send_request(OP_LOAD_OWNER, e, 0, $urandom_range(0, 65535), 0, 0, 0, 0);
                7:
                    send_request(opcode_t'($urandom_range(0, 3)),
                                 $urandom_range(MeshSize, 4095), $urandom_range(0, 15),
                                 $urandom_range(0, 65535), pick_coord(), pick_coord(),
                                 pick_coord(), 0);
                default:
                    send_request(OP_TRACK, e, $urandom_range(0, 15),
                                 $urandom_range(0, 65535), pick_coord(), pick_coord(),
                                 pick_coord(), $urandom_range(0, 9) != 0);
            endcase
        end
        sender_gaps = 1;
    endtask

    initial
    begin
        mesh_sb = new();
        requests_sent = 0;
        tracks_sent = 0;
        stall_cycles = 0;
        hold_off_cycles = 0;
        sender_gaps = 1;
        receiver_gaps = 1;
        push = 0;
        opcode = OP_LOAD_CENTER;
        element_index = 0;
        slot_index = 0;
        table_value = 0;
        coord_x = 0;
        coord_y = 0;
        coord_z = 0;
        point_active = 0;
        cfg_we = 0;
        cfg_index = CFG_ELEMENT_COUNT;
        cfg_data = 0;
        rst_n = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;

        // Reset configuration: all 4096 elements valid, owner map off.
        load_mesh();
        directed_requests();
        random_requests(RandPerPhase);

        // Only element 0 valid: neighbors other than element 0 are out of range.
        write_config(CFG_ELEMENT_COUNT, 1);
        write_config(CFG_OWNER_MAP, 1);
        directed_requests();
        random_requests(RandPerPhase);

        // Full range again. The receiver holds off for a long stretch while
        // tracks keep coming, so the queues fill and full stalls the sender.
        write_config(CFG_ELEMENT_COUNT, 4096);
        receiver_gaps = 0;
        hold_off_cycles = 400;
        for (int k = 0; k < 40; k++)
            send_request(OP_TRACK, $urandom_range(0, MeshSize - 1), 0, 0,
                         pick_coord(), pick_coord(), pick_coord(), 1);
        // The sender waits for every result before going on.
        drain_results();
        receiver_gaps = 1;
        random_requests(RandPerPhase);

        // Part of the mesh valid, owner map off again.
        write_config(CFG_ELEMENT_COUNT, 10);
        write_config(CFG_OWNER_MAP, 0);
        random_requests(RandPerPhase);

        drain_results();
        repeat (DrainCycles) @(negedge clk);

        $display("Sent %0d requests, %0d of them active tracks, over four settings",
                 requests_sent, tracks_sent);
        $display("Checked %0d walk results, %0d mismatches",
                 mesh_sb.results_checked, mesh_sb.mismatches);
        if (mesh_sb.mismatches == 0 && mesh_sb.expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
hdl/ncmw_pkg.sv
hdl/ncmw_front.sv
hdl/ncmw_back.sv
hdl/nearest_center_mesh_walk.sv
sim/tb.sv
